// File: src/gf256_parity_stream_encoder_unit_assert.svh
// Assertion macros used by the checker file of the parity encoder.
`ifndef GF256_PARITY_STREAM_ENCODER_UNIT_ASSERT_SVH
`define GF256_PARITY_STREAM_ENCODER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define GPSE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: check failed");

// Clocked assertion that also holds while reset is asserted.
`define GPSE_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: reset check failed");

`endif

// File: src/gpse_pkg.sv
// Shared types, constants and a helper function of the GF(2^8) parity encoder.
`timescale 1ns / 1ps
`default_nettype none

package gpse_pkg;

    localparam int DEF_MAX_DATA     = 16;
    localparam int DEF_MAX_PARITY   = 8;
    localparam int DEF_MAX_FRAGMENT = 4096;

    localparam int CFG_WIDTH = 13;

    localparam logic [4:0]  RST_DATA_FRAGMENTS   = 5'd1;
    localparam logic [3:0]  RST_PARITY_FRAGMENTS = 4'd1;
    localparam logic [12:0] RST_FRAGMENT_LENGTH  = 13'd4096;
    localparam logic [7:0]  RST_FIELD_POLYNOMIAL = 8'h1d;

    localparam logic [7:0] BYTE_MASK = 8'hff;

    localparam logic KIND_COEF = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [1:0] {
        CFG_DATA_FRAGMENTS   = 2'd0,
        CFG_PARITY_FRAGMENTS = 2'd1,
        CFG_FRAGMENT_LENGTH  = 2'd2,
        CFG_FIELD_POLYNOMIAL = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic       kind;
        logic [2:0] coef_row;
        logic [3:0] coef_col;
        logic [7:0] byte_value;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  parity_row;
        logic [11:0] byte_position;
        logic [7:0]  parity_value;
        logic        last;
    } t_out_beat;

    // A count of zero acts as one; a count above the limit saturates.
    function automatic logic [31:0] clamp_count(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] res;
        if (v == 32'd0) begin
            res = 32'd1;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/gf256_parity_stream_encoder_unit.sv
// Top level of the GF(2^8) erasure-code parity encoder: sequencer and memories.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_beat)
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A coefficient beat is taken in S_IDLE and does not leave it. A data beat is accepted in
// S_IDLE; then each active parity row passes S_READ, which reads the coefficient and parity
// RAMs, and S_MAC, which multiplies, writes the parity RAM back and, in the last fragment,
// loads the output register; a full output register under stall holds the write-back cycle.
// Reset is synchronous; it clears the counters, the control state and the output valid flag
// and loads the config defaults, while both RAMs keep their contents and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gf256_parity_stream_encoder_unit #(
    parameter int MAX_DATA     = gpse_pkg::DEF_MAX_DATA,
    parameter int MAX_PARITY   = gpse_pkg::DEF_MAX_PARITY,
    parameter int MAX_FRAGMENT = gpse_pkg::DEF_MAX_FRAGMENT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire gpse_pkg::t_in_beat            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output gpse_pkg::t_out_beat                o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire gpse_pkg::t_cfg_index          i_cfg_index,
    input  wire logic [gpse_pkg::CFG_WIDTH-1:0] i_cfg_data
);
    import gpse_pkg::*;

    localparam int RW  = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int FW  = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int PW  = $clog2(MAX_FRAGMENT);
    localparam int CAW = RW + FW;
    localparam int PAW = RW + PW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MAC
    } t_state;

    t_state      r_state;
    logic [4:0]  r_cfg_nd;
    logic [3:0]  r_cfg_np;
    logic [12:0] r_cfg_len;
    logic [7:0]  r_cfg_poly;
    logic [PW-1:0] r_pos;
    logic [FW-1:0] r_frag;
    logic [RW-1:0] r_row;
    logic [7:0]  r_byte;
    logic        r_out_valid;
    t_out_beat   r_out_data;

    logic [31:0] nd32;
    logic [31:0] np32;
    logic [31:0] len32;
    logic        in_acc;
    logic        wrap;
    logic        emit;
    logic        first;
    logic        row_last;
    logic        out_free;
    logic        mac_go;
    logic        coef_we;
    logic [CAW-1:0] coef_waddr;
    logic [CAW-1:0] coef_raddr;
    logic [PAW-1:0] par_addr;
    logic [7:0]  coef_q;
    logic [7:0]  par_q;
    logic [7:0]  mac_val;

    assign nd32  = clamp_count(32'(r_cfg_nd), 32'(MAX_DATA));
    assign np32  = clamp_count(32'(r_cfg_np), 32'(MAX_PARITY));
    assign len32 = clamp_count(32'(r_cfg_len), 32'(MAX_FRAGMENT));

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign wrap     = (32'(r_pos) >= len32) || (32'(r_frag) >= nd32);
    assign emit     = (32'(r_frag) + 32'd1) == nd32;
    assign first    = (r_frag == '0);
    assign row_last = (32'(r_row) + 32'd1) == np32;
    assign out_free = !r_out_valid || !i_out_stall;
    assign mac_go   = (r_state == S_MAC) && (!emit || out_free);

    // Coefficient loads outside the matrix are dropped.
    assign coef_we = in_acc && (i_in_data.kind == KIND_COEF)
                     && (32'(i_in_data.coef_row) < 32'(MAX_PARITY))
                     && (32'(i_in_data.coef_col) < 32'(MAX_DATA));
    assign coef_waddr = {RW'(i_in_data.coef_row), FW'(i_in_data.coef_col)};
    assign coef_raddr = {r_row, r_frag};
    assign par_addr   = {r_row, r_pos};

    gpse_ram #(
        .W  (8),
        .AW (CAW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_in_data.byte_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_q)
    );

    gpse_ram #(
        .W  (8),
        .AW (PAW)
    ) u_parity_ram (
        .i_clk   (i_clk),
        .i_we    (mac_go),
        .i_waddr (par_addr),
        .i_wdata (mac_val),
        .i_raddr (par_addr),
        .o_rdata (par_q)
    );

    gpse_gf_mac u_mac (
        .i_coef  (coef_q),
        .i_data  (r_byte),
        .i_poly  (r_cfg_poly),
        .i_old   (par_q),
        .i_first (first),
        .o_value (mac_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_nd    <= RST_DATA_FRAGMENTS;
            r_cfg_np    <= RST_PARITY_FRAGMENTS;
            r_cfg_len   <= RST_FRAGMENT_LENGTH;
            r_cfg_poly  <= RST_FIELD_POLYNOMIAL;
            r_pos       <= '0;
            r_frag      <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DATA_FRAGMENTS:   r_cfg_nd   <= i_cfg_data[4:0];
                    CFG_PARITY_FRAGMENTS: r_cfg_np   <= i_cfg_data[3:0];
                    CFG_FRAGMENT_LENGTH:  r_cfg_len  <= i_cfg_data[12:0];
                    CFG_FIELD_POLYNOMIAL: r_cfg_poly <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (mac_go && emit) begin
                r_out_valid <= 1'b1;
                r_out_data.parity_row    <= 3'(r_row);
                r_out_data.byte_position <= 12'(r_pos);
                r_out_data.parity_value  <= mac_val;
                r_out_data.last          <= row_last;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in_data.kind == KIND_DATA)) begin
                        r_byte  <= i_in_data.byte_value;
                        r_row   <= '0;
                        // A register change may leave the counters outside the stripe.
                        if (wrap) begin
                            r_pos  <= '0;
                            r_frag <= '0;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (mac_go) begin
                        if (row_last) begin
                            if ((32'(r_pos) + 32'd1) >= len32) begin
                                r_pos <= '0;
                                if ((32'(r_frag) + 32'd1) >= nd32) begin
                                    r_frag <= '0;
                                end else begin
                                    r_frag <= r_frag + FW'(1);
                                end
                            end else begin
                                r_pos <= r_pos + PW'(1);
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + RW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: src/gpse_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gpse_ram #(
    parameter int W  = 8,
    parameter int AW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/gpse_gf_mac.sv
// GF(2^8) multiply by a programmable polynomial, accumulated into a parity byte.
`timescale 1ns / 1ps
`default_nettype none

module gpse_gf_mac (
    input  wire logic [7:0] i_coef,
    input  wire logic [7:0] i_data,
    input  wire logic [7:0] i_poly,
    input  wire logic [7:0] i_old,
    input  wire logic       i_first,
    output logic      [7:0] o_value
);
    import gpse_pkg::*;

    logic [7:0] prod;

    // Shift-and-reduce: eight narrow steps, the polynomial need not be irreducible.
    always_comb begin
        logic [7:0] a;
        logic [7:0] acc;
        a   = i_coef;
        acc = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (i_data[i]) begin
                acc = acc ^ a;
            end
            if (a[7]) begin
                a = {a[6:0], 1'b0} ^ i_poly;
            end else begin
                a = {a[6:0], 1'b0};
            end
        end
        prod = acc & BYTE_MASK;
    end

    // The first data fragment overwrites the stored parity.
    assign o_value = i_first ? prod : (i_old ^ prod);

endmodule

`default_nettype wire

// File: src/gpse_checker.sv
// Port-level checker of the parity encoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "gf256_parity_stream_encoder_unit_assert.svh"

module gpse_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire gpse_pkg::t_in_beat  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire gpse_pkg::t_out_beat o_out_data
);
    import gpse_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // A held output beat keeps its payload.
    `GPSE_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))

    // A coefficient beat into an empty block produces no output.
    `GPSE_ASSERT(a_coef_silent, i_clk, i_rst_n, (in_acc && (i_in_data.kind == KIND_COEF) && !o_out_valid) |=> !o_out_valid)

    // A data beat keeps the block busy at least for its read cycle.
    `GPSE_ASSERT(a_data_busy, i_clk, i_rst_n, (in_acc && (i_in_data.kind == KIND_DATA)) |=> o_in_stall)

    // Reset leaves the block idle with nothing to deliver.
    `GPSE_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall))

endmodule

bind gf256_parity_stream_encoder_unit gpse_checker u_gpse_checker (.*);

`default_nettype wire
